[hdl/censor_region_tracker_mask_defines.svh]
// Assertion helpers shared by the tracker RTL.
`ifndef CENSOR_REGION_TRACKER_MASK_DEFINES_SVH
`define CENSOR_REGION_TRACKER_MASK_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define CRTM_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("crtm same-cycle check failed");

// Next-cycle implication, sampled on clock, off while reset is high.
`define CRTM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("crtm next-cycle check failed");

`endif

[hdl/crtm_pkg.sv]
package crtm_pkg;

   localparam int CELL_IDX_BITS = 8;   // covers tables of up to 256 entries
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 36;

   localparam logic [1:0] ACT_ADD = 2'd0;
   localparam logic [1:0] ACT_PRUNE = 2'd1;
   localparam logic [1:0] ACT_MASK = 2'd2;

   localparam logic [1:0] STATUS_MERGED = 2'd0;
   localparam logic [1:0] STATUS_APPENDED = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;
   localparam logic [1:0] STATUS_EMPTY = 2'd3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PAD_FRACTION = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REGION_LIFETIME = 2'd1;

   localparam logic [15:0] PAD_FRACTION_RESET = 16'd19661;
   localparam logic [35:0] REGION_LIFETIME_RESET = 36'd2500000000;

   localparam logic signed [19:0] UNIT_Q15 = 20'sd32768;
   localparam logic [63:0] FULL_AGE_NS = 64'd300000000;
   localparam logic [14:0] MAX_INFLATE_Q16 = 15'd16384;
   // floor(2^43 / 300e6): age * this >> 29 is at most one below age * 2^14 / 300e6
   localparam logic [14:0] AGE_RECIP = 15'd29320;
   localparam logic [14:0] HALF_CELL_Q15 = 15'd16384;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] box_x;
      logic [15:0] box_y;
      logic [15:0] box_w;
      logic [15:0] box_h;
      logic [63:0] now_time;
      logic [7:0]  mask_row;
      logic [2:0]  mask_column_word;
   } req_type;

   typedef struct packed {
      logic [1:0]  add_status;
      logic [6:0]  region_total;
      logic [63:0] mask_bits;
   } rsp_type;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] w;
      logic [15:0] h;
   } box_type;

   typedef struct packed {
      box_type     box;
      logic [63:0] seen;
   } entry_type;

   typedef struct packed {
      logic                     shift;
      logic                     push;
      logic                     load;
      logic [CELL_IDX_BITS-1:0] tail_idx;
      logic [CELL_IDX_BITS-1:0] load_idx;
      entry_type                feed;
   } cell_ctl_type;

   typedef struct packed {
      logic clear;
      logic valid;
   } rast_ctl_type;

endpackage

[hdl/crtm_cell.sv]
module crtm_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                   clock,
   input  crtm_pkg::cell_ctl_type ctl,
   input  crtm_pkg::entry_type    right,
   output crtm_pkg::entry_type    q
);

   localparam logic [crtm_pkg::CELL_IDX_BITS-1:0] MY_IDX =
      crtm_pkg::CELL_IDX_BITS'(CELL_INDEX);

   crtm_pkg::entry_type entry_ff;
   crtm_pkg::entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.load && ctl.load_idx == MY_IDX) begin
         entry_in = ctl.feed;
      end else if (ctl.shift) begin
         // the tail of the window takes the pushed entry, cells below it advance
         if (ctl.push && ctl.tail_idx == MY_IDX) begin
            entry_in = ctl.feed;
         end else if (MY_IDX < ctl.tail_idx) begin
            entry_in = right;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;

endmodule

[hdl/crtm_raster.sv]
module crtm_raster #(
   parameter int MASK_COLUMNS = 320,
   parameter int MASK_ROWS = 180
) (
   input  logic                   clock,
   input  logic                   reset,
   input  crtm_pkg::rast_ctl_type ctl,
   input  crtm_pkg::entry_type    entry,
   input  logic [63:0]            now_time,
   input  logic [7:0]             mask_row,
   input  logic [2:0]             mask_column_word,
   output logic [63:0]            mask_bits,
   output logic                   busy
);

   // span ends reach at most 1.25 * 1024 cells
   localparam int COORD_BITS = 11;
   localparam logic [COORD_BITS-1:0] COLS = COORD_BITS'(MASK_COLUMNS);
   localparam logic [COORD_BITS-1:0] ROWS = COORD_BITS'(MASK_ROWS);

   function automatic logic [COORD_BITS-1:0] span_lo(input logic signed [17:0] s,
                                                     input logic [COORD_BITS-1:0] n_cells);
      logic [27:0] prod;
      prod = 28'(s[16:0]) * 28'(n_cells);
      if (s < 0) begin
         span_lo = '0;
      end else begin
         span_lo = prod[15 +: COORD_BITS];
      end
   endfunction

   function automatic logic [COORD_BITS-1:0] span_hi(input logic signed [17:0] s,
                                                     input logic [COORD_BITS-1:0] n_cells);
      logic [27:0] prod;
      logic [COORD_BITS-1:0] hi;
      prod = 28'(s[16:0]) * 28'(n_cells) + 28'(crtm_pkg::HALF_CELL_Q15);
      hi = prod[15 +: COORD_BITS];
      if (s < 0) begin
         span_hi = '0;
      end else if (hi > n_cells) begin
         span_hi = n_cells;
      end else begin
         span_hi = hi;
      end
   endfunction

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   crtm_pkg::box_type box1_ff, box2_ff, box3_ff;
   logic [28:0] a1_ff, a2_ff;
   logic full1_ff, full2_ff;
   logic [43:0] p2_ff;
   logic [14:0] infl3_ff;
   logic signed [17:0] sx4_ff, ex4_ff, sy4_ff, ey4_ff;
   logic [COORD_BITS-1:0] x0_ff, x1_ff, y0_ff, y1_ff;
   logic [63:0] acc_ff;

   logic [63:0] age;
   logic [43:0] p_in;
   logic [14:0] q0;
   logic [43:0] chk;
   logic [14:0] infl_in;
   logic [30:0] prod_w, prod_h;
   logic [14:0] pad_x, pad_y;
   logic signed [17:0] sx_in, ex_in, sy_in, ey_in;
   logic [COORD_BITS-1:0] col_base;
   logic hit_row;
   logic [63:0] row_bits;

   always_comb begin
      age = now_time - entry.seen;
      p_in = 44'(a1_ff) * 44'(crtm_pkg::AGE_RECIP);
      q0 = p2_ff[43:29];
      chk = 44'(q0 + 15'd1) * 44'(crtm_pkg::FULL_AGE_NS);
      if (full2_ff) begin
         infl_in = crtm_pkg::MAX_INFLATE_Q16;
      end else if ({1'b0, a2_ff, 14'b0} >= chk) begin
         infl_in = q0 + 15'd1;
      end else begin
         infl_in = q0;
      end
      prod_w = 31'(box3_ff.w) * 31'(infl3_ff);
      prod_h = 31'(box3_ff.h) * 31'(infl3_ff);
      pad_x = prod_w[30:16];
      pad_y = prod_h[30:16];
      sx_in = $signed({2'b0, box3_ff.x}) - $signed({3'b0, pad_x});
      ex_in = $signed({2'b0, box3_ff.x}) + $signed({2'b0, box3_ff.w})
              + $signed({3'b0, pad_x});
      sy_in = $signed({2'b0, box3_ff.y}) - $signed({3'b0, pad_y});
      ey_in = $signed({2'b0, box3_ff.y}) + $signed({2'b0, box3_ff.h})
              + $signed({3'b0, pad_y});
      col_base = {2'b0, mask_column_word, 6'b0};
      hit_row = ({3'b0, mask_row} >= y0_ff) && ({3'b0, mask_row} < y1_ff);
      for (int i = 0; i < 64; i++) begin
         row_bits[i] = hit_row && ((col_base + COORD_BITS'(i)) >= x0_ff)
                       && ((col_base + COORD_BITS'(i)) < x1_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= ctl.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      box1_ff <= entry.box;
      a1_ff <= age[28:0];
      full1_ff <= age >= crtm_pkg::FULL_AGE_NS;
      box2_ff <= box1_ff;
      a2_ff <= a1_ff;
      full2_ff <= full1_ff;
      p2_ff <= p_in;
      box3_ff <= box2_ff;
      infl3_ff <= infl_in;
      sx4_ff <= sx_in;
      ex4_ff <= ex_in;
      sy4_ff <= sy_in;
      ey4_ff <= ey_in;
      x0_ff <= span_lo(sx4_ff, COLS);
      x1_ff <= span_hi(ex4_ff, COLS);
      y0_ff <= span_lo(sy4_ff, ROWS);
      y1_ff <= span_hi(ey4_ff, ROWS);
      if (ctl.clear) begin
         acc_ff <= '0;
      end else if (v5_ff) begin
         acc_ff <= acc_ff | row_bits;
      end
   end

   assign mask_bits = acc_ff;
   assign busy = v1_ff | v2_ff | v3_ff | v4_ff | v5_ff;

endmodule

[hdl/censor_region_tracker_mask.sv]
// Region tracker with coverage mask.
// Input channel req_valid / req_stall / req_data carries one item: add a box,
// prune expired regions, or read one 64-bit word of the coverage mask.
// Result channel rsp_valid / rsp_stall / rsp_data returns exactly one result
// per item. Registers are written through csr_write_en / csr_index / csr_wdata;
// the user must write them only while the block is idle; the block itself
// does not enforce it. The table lives in a row of MAX_REGION_ENTRIES cells
// that rotate one entry a cycle past a head unit; an add, prune or mask read
// visits every stored entry. An add whose box is empty after clamping skips
// the sweep, and a mask read also waits for the five raster stages to drain
// after the sweep. One item is worked on at a time; the next item is taken as
// soon as the previous result sits in the output register.
// A stalled result holds in the output register; if a second result finishes
// while the first is still stalled, the block waits before taking new input.
// Synchronous reset empties the table and restores the register defaults;
// no clearing pass is needed.
`include "censor_region_tracker_mask_defines.svh"

module censor_region_tracker_mask #(
   parameter int MAX_REGION_ENTRIES = 64,
   parameter int MASK_COLUMNS = 320,
   parameter int MASK_ROWS = 180
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  crtm_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output crtm_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_write_en,
   input  logic [crtm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [crtm_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int CNT_W = $clog2(MAX_REGION_ENTRIES + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REGION_ENTRIES);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PAD   = 6'b000010,
      ST_CLAMP = 6'b000100,
      ST_SCAN  = 6'b001000,
      ST_DRAIN = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] used_ff, used_in, win_ff, win_in, left_ff, left_in;
   logic merged_ff, merged_in;
   logic [1:0] status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [15:0] pad_ff;
   logic [35:0] life_ff;
   crtm_pkg::req_type req_ff;
   crtm_pkg::rsp_type rsp_data_ff;
   crtm_pkg::entry_type nb_ff;
   logic [15:0] pw_ff, ph_ff;

   logic req_load, nb_load, rsp_load;
   crtm_pkg::cell_ctl_type cell_ctl;
   crtm_pkg::rast_ctl_type rast_ctl;
   crtm_pkg::entry_type slot_q [MAX_REGION_ENTRIES];
   crtm_pkg::entry_type head;
   logic [63:0] rast_bits;
   logic rast_busy;

   logic [31:0] pw_prod, ph_prod;
   logic signed [19:0] cx, cw, cy, ch;
   logic box_empty;
   logic [16:0] head_r, head_b, nb_r, nb_b, mr, mb;
   logic [15:0] mx, my;
   logic overlap;
   crtm_pkg::entry_type merged_entry;
   logic [63:0] head_age;
   logic keep;

   assign head = slot_q[0];

   // padding and clamp of the incoming box
   always_comb begin
      pw_prod = 32'(req_ff.box_w) * 32'(pad_ff);
      ph_prod = 32'(req_ff.box_h) * 32'(pad_ff);
      cx = $signed({4'b0, req_ff.box_x}) - $signed({4'b0, pw_ff});
      cw = $signed({4'b0, req_ff.box_w}) + $signed({3'b0, pw_ff, 1'b0});
      cy = $signed({4'b0, req_ff.box_y}) - $signed({4'b0, ph_ff});
      ch = $signed({4'b0, req_ff.box_h}) + $signed({3'b0, ph_ff, 1'b0});
      if (cx < 0) begin
         cw = cw + cx;
         cx = '0;
      end
      if (cy < 0) begin
         ch = ch + cy;
         cy = '0;
      end
      if (cx + cw > crtm_pkg::UNIT_Q15) begin
         cw = crtm_pkg::UNIT_Q15 - cx;
      end
      if (cy + ch > crtm_pkg::UNIT_Q15) begin
         ch = crtm_pkg::UNIT_Q15 - cy;
      end
      box_empty = (cw <= 0) || (ch <= 0);
   end

   // head compare and union against the new box, and age test for pruning
   always_comb begin
      head_r = {1'b0, head.box.x} + {1'b0, head.box.w};
      head_b = {1'b0, head.box.y} + {1'b0, head.box.h};
      nb_r = {1'b0, nb_ff.box.x} + {1'b0, nb_ff.box.w};
      nb_b = {1'b0, nb_ff.box.y} + {1'b0, nb_ff.box.h};
      overlap = ({1'b0, head.box.x} < nb_r) && ({1'b0, nb_ff.box.x} < head_r)
                && ({1'b0, head.box.y} < nb_b) && ({1'b0, nb_ff.box.y} < head_b);
      mx = (head.box.x < nb_ff.box.x) ? head.box.x : nb_ff.box.x;
      my = (head.box.y < nb_ff.box.y) ? head.box.y : nb_ff.box.y;
      mr = (head_r > nb_r) ? head_r : nb_r;
      mb = (head_b > nb_b) ? head_b : nb_b;
      merged_entry.box.x = mx;
      merged_entry.box.y = my;
      merged_entry.box.w = 16'(mr - {1'b0, mx});
      merged_entry.box.h = 16'(mb - {1'b0, my});
      merged_entry.seen = req_ff.now_time;
      head_age = req_ff.now_time - head.seen;
      keep = head_age < {28'b0, life_ff};
   end

   always_comb begin
      state_in = state_ff;
      used_in = used_ff;
      win_in = win_ff;
      left_in = left_ff;
      merged_in = merged_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_load = 1'b0;
      nb_load = 1'b0;
      rsp_load = 1'b0;
      cell_ctl = '0;
      cell_ctl.feed = head;
      cell_ctl.tail_idx = crtm_pkg::CELL_IDX_BITS'(win_ff - CNT_W'(1));
      cell_ctl.load_idx = crtm_pkg::CELL_IDX_BITS'(used_ff);
      rast_ctl = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_load = 1'b1;
               rast_ctl.clear = 1'b1;
               merged_in = 1'b0;
               status_in = crtm_pkg::STATUS_MERGED;
               left_in = used_ff;
               win_in = used_ff;
               case (req_data.action)
                  crtm_pkg::ACT_ADD: state_in = ST_PAD;
                  crtm_pkg::ACT_PRUNE: state_in = ST_SCAN;
                  crtm_pkg::ACT_MASK: state_in = ST_SCAN;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_PAD: begin
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            if (box_empty) begin
               status_in = crtm_pkg::STATUS_EMPTY;
               state_in = ST_DONE;
            end else begin
               nb_load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (left_ff == '0) begin
               case (req_ff.action)
                  crtm_pkg::ACT_ADD: begin
                     state_in = ST_DONE;
                     if (merged_ff) begin
                        status_in = crtm_pkg::STATUS_MERGED;
                     end else if (used_ff < MAX_CNT) begin
                        cell_ctl.load = 1'b1;
                        cell_ctl.feed = nb_ff;
                        used_in = used_ff + CNT_W'(1);
                        status_in = crtm_pkg::STATUS_APPENDED;
                     end else begin
                        status_in = crtm_pkg::STATUS_FULL;
                     end
                  end
                  crtm_pkg::ACT_PRUNE: begin
                     used_in = win_ff;
                     state_in = ST_DONE;
                  end
                  default: state_in = ST_DRAIN;
               endcase
            end else begin
               // pop the head; push it back at the window tail unless pruned
               left_in = left_ff - CNT_W'(1);
               cell_ctl.shift = 1'b1;
               cell_ctl.push = 1'b1;
               case (req_ff.action)
                  crtm_pkg::ACT_ADD: begin
                     if (!merged_ff && overlap) begin
                        cell_ctl.feed = merged_entry;
                        merged_in = 1'b1;
                     end
                  end
                  crtm_pkg::ACT_PRUNE: begin
                     if (!keep) begin
                        cell_ctl.push = 1'b0;
                        win_in = win_ff - CNT_W'(1);
                     end
                  end
                  default: rast_ctl.valid = 1'b1;
               endcase
            end
         end
         ST_DRAIN: begin
            if (!rast_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff <= '0;
         win_ff <= '0;
         left_ff <= '0;
         merged_ff <= 1'b0;
         status_ff <= crtm_pkg::STATUS_MERGED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         win_ff <= win_in;
         left_ff <= left_in;
         merged_ff <= merged_in;
         status_ff <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_ff <= crtm_pkg::PAD_FRACTION_RESET;
         life_ff <= crtm_pkg::REGION_LIFETIME_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            crtm_pkg::CSR_PAD_FRACTION: pad_ff <= csr_wdata[15:0];
            crtm_pkg::CSR_REGION_LIFETIME: life_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_load) begin
         req_ff <= req_data;
      end
      if (state_ff == ST_PAD) begin
         pw_ff <= pw_prod[31:16];
         ph_ff <= ph_prod[31:16];
      end
      if (nb_load) begin
         nb_ff.box.x <= cx[15:0];
         nb_ff.box.y <= cy[15:0];
         nb_ff.box.w <= cw[15:0];
         nb_ff.box.h <= ch[15:0];
         nb_ff.seen <= req_ff.now_time;
      end
      if (rsp_load) begin
         rsp_data_ff.add_status <= status_ff;
         rsp_data_ff.region_total <= 7'(used_ff);
         rsp_data_ff.mask_bits <= (req_ff.action == crtm_pkg::ACT_MASK) ? rast_bits : '0;
      end
   end

   for (genvar i = 0; i < MAX_REGION_ENTRIES; i++) begin : g_slot
      if (i == MAX_REGION_ENTRIES - 1) begin : g_last
         crtm_cell #(.CELL_INDEX(i)) u_slot (
            .clock (clock),
            .ctl   (cell_ctl),
            .right (cell_ctl.feed),
            .q     (slot_q[i])
         );
      end else begin : g_mid
         crtm_cell #(.CELL_INDEX(i)) u_slot (
            .clock (clock),
            .ctl   (cell_ctl),
            .right (slot_q[i+1]),
            .q     (slot_q[i])
         );
      end
   end

   crtm_raster #(
      .MASK_COLUMNS (MASK_COLUMNS),
      .MASK_ROWS    (MASK_ROWS)
   ) u_raster (
      .clock            (clock),
      .reset            (reset),
      .ctl              (rast_ctl),
      .entry            (head),
      .now_time         (req_ff.now_time),
      .mask_row         (req_ff.mask_row),
      .mask_column_word (req_ff.mask_column_word),
      .mask_bits        (rast_bits),
      .busy             (rast_busy)
   );

   // hold off input while in reset so no transfer is seen there
   assign req_stall = (state_ff != ST_IDLE) || reset;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   `CRTM_ASSERT_NEXT(a_used_step, 1'b1, {1'b0, used_ff} <= {1'b0, $past(used_ff)} + 1'b1)
   `CRTM_ASSERT_IMP(a_window_bound, state_ff == ST_SCAN, win_ff <= used_ff && left_ff <= win_ff)
   `CRTM_ASSERT_NEXT(a_rsp_source, state_ff != ST_DONE && !(rsp_valid_ff && rsp_stall), !rsp_valid_ff)
   `CRTM_ASSERT_IMP(a_raster_idle, state_ff == ST_IDLE, !rast_busy)

endmodule
